// File: src/gcc_pkg.sv
// Shared types and constants for the graph connectivity checker.
// No dependencies; every other source file imports this package.
`default_nettype none

package gcc_pkg;

  localparam int MAX_NODES_DEFAULT = 64;

  localparam int FIELD_NODE_W = 6;
  localparam int FIELD_CNT_W  = 7;
  localparam int FIELD_WGT_W  = 32;

  localparam logic ACT_EDGE  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic REG_NODE_COUNT = 1'b0;
  localparam logic REG_UNDIRECTED = 1'b1;

  localparam logic [FIELD_CNT_W-1:0] NODE_COUNT_RESET = '0;
  localparam logic                   UNDIRECTED_RESET = 1'b1;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_BAD_IDX = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE_RD,
    ST_EDGE_SRC,
    ST_EDGE_DST,
    ST_WALK
  } state_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } adj_ctl_t;

endpackage

`default_nettype wire

// File: src/gcc_adj_mem.sv
// Adjacency row memory: one write port, one registered read port.
// Per-row valid bits make unwritten rows read as zero after reset. Uses gcc_pkg.
`default_nettype none

module gcc_adj_mem
  import gcc_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEFAULT,
  parameter int NODE_W    = $clog2(MAX_NODES)
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire adj_ctl_t             ctl,
  input  wire logic [NODE_W-1:0]    wr_addr,
  input  wire logic [MAX_NODES-1:0] wr_data,
  input  wire logic [NODE_W-1:0]    rd_addr,
  output logic      [MAX_NODES-1:0] rd_data
);

  logic [MAX_NODES-1:0] mem [MAX_NODES];
  logic [MAX_NODES-1:0] row_valid;
  logic [MAX_NODES-1:0] rd_q;
  logic                 rd_ok;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_ok     <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rd_ok <= row_valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_ok ? rd_q : '0;

endmodule

`default_nettype wire

// File: src/gcc_ctrl.sv
// Request sequencer: edge read-modify-write and the reachability walk.
// Drives gcc_adj_mem through an adj_ctl_t bundle. Uses gcc_pkg.
`default_nettype none

module gcc_ctrl
  import gcc_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEFAULT,
  parameter int NODE_W    = $clog2(MAX_NODES),
  parameter int CNT_W     = $clog2(MAX_NODES + 1)
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic                    action,
  input  wire logic [FIELD_NODE_W-1:0] source_node,
  input  wire logic [FIELD_NODE_W-1:0] target_node,
  input  wire logic [FIELD_WGT_W-1:0]  edge_weight,
  input  wire logic [CNT_W-1:0]        cnt,
  input  wire logic                    undirected,
  output adj_ctl_t                     mem_ctl,
  output logic      [NODE_W-1:0]       mem_wr_addr,
  output logic      [MAX_NODES-1:0]    mem_wr_data,
  output logic      [NODE_W-1:0]       mem_rd_addr,
  input  wire logic [MAX_NODES-1:0]    mem_rd_data,
  output logic                         done,
  output logic                         status,
  output logic                         is_connected,
  output logic      [FIELD_CNT_W-1:0]  reached_count
);

  state_t state, state_next;

  logic [NODE_W-1:0]    src_idx;
  logic [NODE_W-1:0]    dst_idx;
  logic                 present;
  logic                 same_node;
  logic [MAX_NODES-1:0] active_mask;
  logic [MAX_NODES-1:0] visited;
  logic [MAX_NODES-1:0] pending;
  logic [CNT_W-1:0]     count;
  logic                 inflight;

  logic                 accept;
  logic                 bad_idx;
  logic                 mirror;
  logic                 have;
  logic                 walk_end;
  logic                 finish;
  logic [MAX_NODES-1:0] pick_oh;
  logic [NODE_W-1:0]    pick_idx;
  logic [MAX_NODES-1:0] new_bits;
  logic [MAX_NODES-1:0] mask_now;
  logic                 first_node;

  assign accept    = start && (state == ST_IDLE);
  assign bad_idx   = (int'(source_node) >= int'(cnt)) || (int'(target_node) >= int'(cnt));
  assign mirror    = undirected && !same_node;
  assign have      = |pending;
  assign walk_end  = !have && !inflight;
  assign pick_oh   = pending & (~pending + MAX_NODES'(1));
  assign new_bits  = inflight ? (mem_rd_data & active_mask & ~visited) : '0;
  assign first_node = (cnt != '0);

  always_comb begin
    pick_idx = '0;
    for (int i = 0; i < MAX_NODES; i++) begin
      if (pick_oh[i]) begin
        pick_idx = pick_idx | NODE_W'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) begin
      mask_now[i] = (CNT_W'(i) < cnt);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (action == ACT_QUERY) begin
            state_next = ST_WALK;
          end else if (!bad_idx) begin
            state_next = ST_EDGE_RD;
          end
        end
      end
      ST_EDGE_RD:  state_next = ST_EDGE_SRC;
      ST_EDGE_SRC: state_next = mirror ? ST_EDGE_DST : ST_IDLE;
      ST_EDGE_DST: state_next = ST_IDLE;
      ST_WALK:     state_next = walk_end ? ST_IDLE : ST_WALK;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_ctl     = '0;
    mem_rd_addr = src_idx;
    mem_wr_addr = src_idx;
    mem_wr_data = mem_rd_data;
    finish      = 1'b0;
    busy        = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        finish = accept && (action == ACT_EDGE) && bad_idx;
      end
      ST_EDGE_RD: begin
        mem_ctl.rd_en = 1'b1;
      end
      ST_EDGE_SRC: begin
        mem_ctl.wr_en        = 1'b1;
        mem_wr_data[dst_idx] = present;
        mem_ctl.rd_en        = mirror;
        mem_rd_addr          = dst_idx;
        finish               = !mirror;
      end
      ST_EDGE_DST: begin
        mem_ctl.wr_en        = 1'b1;
        mem_wr_addr          = dst_idx;
        mem_wr_data[src_idx] = present;
        finish               = 1'b1;
      end
      ST_WALK: begin
        mem_ctl.rd_en = have;
        mem_rd_addr   = pick_idx;
        finish        = walk_end;
      end
      default: begin
        finish = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      done     <= 1'b0;
      inflight <= 1'b0;
    end else begin
      state    <= state_next;
      done     <= finish;
      inflight <= (state == ST_WALK) && have;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      src_idx     <= NODE_W'(source_node);
      dst_idx     <= NODE_W'(target_node);
      present     <= !edge_weight[FIELD_WGT_W-1] && (edge_weight != '0);
      same_node   <= (source_node == target_node);
      active_mask <= mask_now;
      visited     <= MAX_NODES'(first_node);
      pending     <= MAX_NODES'(first_node);
      count       <= '0;
    end else if (state == ST_WALK) begin
      visited <= visited | new_bits;
      pending <= (pending & ~pick_oh) | new_bits;
      count   <= count + CNT_W'(have);
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      if (state == ST_WALK) begin
        status        <= STATUS_OK;
        is_connected  <= (count == cnt);
        reached_count <= FIELD_CNT_W'(count);
      end else begin
        status        <= (state == ST_IDLE) ? STATUS_BAD_IDX : STATUS_OK;
        is_connected  <= 1'b0;
        reached_count <= '0;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/graph_connectivity_checker_unit.sv
// Top level of the graph connectivity checker: configuration registers,
// request sequencer and adjacency memory. Uses gcc_pkg, gcc_ctrl, gcc_adj_mem.
//
// Usage:
// A request is taken when start is high and busy is low. Action edge writes
// bit target_node of row source_node (set when edge_weight, read as signed, is 1 or more) and,
// in undirected mode, the mirrored bit. Action query walks the graph from
// node 0 over the active nodes and reports is_connected and reached_count.
// Every request gives one result, shown for one cycle with done high.
// An edge write with a bad index answers in the cycle after it is taken; a
// good edge write reads the source row, writes it back and, with a mirrored
// bit, writes the target row: read-modify-write passes over the one write
// port of the memory. A query reads one row per reached node and ends once
// no node is pending and no row read is in flight. With no active nodes it
// ends without reading a row.
// One request is in work at a time.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data, always
// ready; write only while busy is low. Reset clears the adjacency matrix at
// once through per-row valid bits, so requests are taken right after reset.
// The receiver cannot stall: results are never held.
`default_nettype none

module graph_connectivity_checker_unit
  import gcc_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEFAULT
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic                    action,
  input  wire logic [FIELD_NODE_W-1:0] source_node,
  input  wire logic [FIELD_NODE_W-1:0] target_node,
  input  wire logic [FIELD_WGT_W-1:0]  edge_weight,
  output logic                         done,
  output logic                         status,
  output logic                         is_connected,
  output logic      [FIELD_CNT_W-1:0]  reached_count,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic                    cfg_index,
  input  wire logic [FIELD_CNT_W-1:0]  cfg_data
);

  localparam int NODE_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CNT_W  = $clog2(MAX_NODES + 1);

  logic [FIELD_CNT_W-1:0] node_count;
  logic                   undirected_mode;
  logic [CNT_W-1:0]       cnt;

  adj_ctl_t               mem_ctl;
  logic [NODE_W-1:0]      mem_wr_addr;
  logic [MAX_NODES-1:0]   mem_wr_data;
  logic [NODE_W-1:0]      mem_rd_addr;
  logic [MAX_NODES-1:0]   mem_rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count      <= NODE_COUNT_RESET;
      undirected_mode <= UNDIRECTED_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_NODE_COUNT: node_count      <= cfg_data;
        REG_UNDIRECTED: undirected_mode <= cfg_data[0];
        default:        node_count      <= node_count;
      endcase
    end
  end

  assign cnt = (int'(node_count) > MAX_NODES) ? CNT_W'(MAX_NODES) : CNT_W'(node_count);

  gcc_ctrl #(
    .MAX_NODES (MAX_NODES),
    .NODE_W    (NODE_W),
    .CNT_W     (CNT_W)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .action        (action),
    .source_node   (source_node),
    .target_node   (target_node),
    .edge_weight   (edge_weight),
    .cnt           (cnt),
    .undirected    (undirected_mode),
    .mem_ctl       (mem_ctl),
    .mem_wr_addr   (mem_wr_addr),
    .mem_wr_data   (mem_wr_data),
    .mem_rd_addr   (mem_rd_addr),
    .mem_rd_data   (mem_rd_data),
    .done          (done),
    .status        (status),
    .is_connected  (is_connected),
    .reached_count (reached_count)
  );

  gcc_adj_mem #(
    .MAX_NODES (MAX_NODES),
    .NODE_W    (NODE_W)
  ) u_adj_mem (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mem_ctl),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

endmodule

`default_nettype wire
